[sv/quad_warp_address_gen_core_macros.svh]
// Assertion helpers shared by the warp address generator.
`ifndef QUAD_WARP_ADDRESS_GEN_CORE_MACROS_SVH
`define QUAD_WARP_ADDRESS_GEN_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QWAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QWAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/qwag_pkg.sv]
package qwag_pkg;

    // Image geometry
    localparam int IN_WIDTH   = 640;
    localparam int IN_HEIGHT  = 480;
    localparam int OUT_WIDTH  = 640;
    localparam int OUT_HEIGHT = 480;

    // Field widths
    localparam int XW   = 10;
    localparam int YW   = 9;
    localparam int IDXW = 19;
    localparam int QW   = 16;                 // Q0.16 weight
    localparam int QW1  = QW + 1;             // holds 1.0
    localparam logic [QW1-1:0] Q_ONE = QW1'(1) << QW;

    // Blend widths
    localparam int LXW = XW + QW;             // corner x times weight
    localparam int LYW = YW + QW;
    localparam int BXW = LXW + QW1;           // second blend, Q.32
    localparam int BYW = LYW + QW1;
    localparam int SXW = BXW - 2 * QW;        // integer part
    localparam int SYW = BYW - 2 * QW;

    // Compare width wide enough for any geometry value
    localparam int CW = 13;

    // Exact reciprocal for floor((c << 16) / D) with c < 2^10:
    // numerator below 2^26, so a shift of 26 + clog2(D) is exact.
    localparam int NUMW    = XW + QW;
    localparam int RECW    = 28;
    localparam int SHIFT_U = NUMW + $clog2(OUT_WIDTH);
    localparam int SHIFT_V = NUMW + $clog2(OUT_HEIGHT);
    localparam longint unsigned RECIP_U =
        ((64'd1 << SHIFT_U) + longint'(OUT_WIDTH) - 1) / longint'(OUT_WIDTH);
    localparam longint unsigned RECIP_V =
        ((64'd1 << SHIFT_V) + longint'(OUT_HEIGHT) - 1) / longint'(OUT_HEIGHT);
    localparam int PRODW = XW + RECW;

    // Index ranges for checks
    localparam longint unsigned IDX_SPAN = 64'd1 << IDXW;
    localparam longint unsigned SRC_AREA = longint'(IN_WIDTH) * longint'(IN_HEIGHT);
    localparam longint unsigned DST_AREA = longint'(OUT_WIDTH) * longint'(OUT_HEIGHT);
    localparam longint unsigned SRC_LIMIT = (SRC_AREA < IDX_SPAN) ? SRC_AREA : IDX_SPAN;
    localparam longint unsigned DST_LIMIT = (DST_AREA < IDX_SPAN) ? DST_AREA : IDX_SPAN;

    // Register map
    localparam int AW = 5;
    typedef enum logic [2:0] {
        REG_C1X = 3'd0,
        REG_C1Y = 3'd1,
        REG_C2X = 3'd2,
        REG_C2Y = 3'd3,
        REG_C3X = 3'd4,
        REG_C3Y = 3'd5,
        REG_C4X = 3'd6,
        REG_C4Y = 3'd7
    } t_reg_idx;

    localparam logic [XW-1:0] RST_C1X = XW'(0);
    localparam logic [YW-1:0] RST_C1Y = YW'(0);
    localparam logic [XW-1:0] RST_C2X = XW'(639);
    localparam logic [YW-1:0] RST_C2Y = YW'(0);
    localparam logic [XW-1:0] RST_C3X = XW'(639);
    localparam logic [YW-1:0] RST_C3Y = YW'(479);
    localparam logic [XW-1:0] RST_C4X = XW'(0);
    localparam logic [YW-1:0] RST_C4Y = YW'(479);

endpackage

[sv/quad_warp_address_gen_core.sv]
// Source address generator for a bilinear quad warp. Each input beat is an output
// pixel (out_x, out_y); each output beat is the linear source index inside the quad
// spanned by the four corner registers, together with the linear output index, for
// one byte per pixel. Out-of-range output coordinates saturate to the last column or
// row, and source coordinates saturate to the source image edge. The datapath is a
// five-stage pipeline (input clamp, weights, first blend, second blend, index
// multiply) that takes one beat per clock unless the output stalls; each stage holds
// its beat only while the stage after it is full and stalled. Corners are written
// over the APB port at byte address 4 * index; the user must write them only while
// the pipeline is empty, since the block itself does not enforce this.
`include "quad_warp_address_gen_core_macros.svh"

module quad_warp_address_gen_core
    import qwag_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // pixel coordinates in
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [XW-1:0]   i_out_x,
    input  logic [YW-1:0]   i_out_y,
    // addresses out
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [IDXW-1:0] o_src_index,
    output logic [IDXW-1:0] o_dst_index,
    // configuration
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [AW-1:0]   paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    // corner registers
    logic [XW-1:0] r_c1x, r_c2x, r_c3x, r_c4x;
    logic [YW-1:0] r_c1y, r_c2y, r_c3y, r_c4y;
    t_reg_idx      w_reg_idx;
    logic          w_wr;

    // pipeline control
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    logic w_s1_en, w_s2_en, w_s3_en, w_s4_en, w_s5_en;

    // stage 1: clamped coordinates
    logic [XW-1:0] r_s1_x, n_s1_x;
    logic [YW-1:0] r_s1_y, n_s1_y;

    // stage 2: weights and output index
    logic [PRODW-1:0] w_prod_u, w_prod_v;
    logic [QW-1:0]    r_s2_u, r_s2_v, n_s2_u, n_s2_v;
    logic [QW1-1:0]   r_s2_nu, r_s2_nv, n_s2_nu, n_s2_nv;
    logic [IDXW-1:0]  r_s2_dst, n_s2_dst;

    // stage 3: first blend
    logic [LXW-1:0]  r_s3_top_x, r_s3_bot_x, n_s3_top_x, n_s3_bot_x;
    logic [LYW-1:0]  r_s3_left_y, r_s3_right_y, n_s3_left_y, n_s3_right_y;
    logic [QW-1:0]   r_s3_u, r_s3_v;
    logic [QW1-1:0]  r_s3_nu, r_s3_nv;
    logic [IDXW-1:0] r_s3_dst;

    // stage 4: source coordinates
    logic [BXW-1:0]  w_sx_full;
    logic [BYW-1:0]  w_sy_full;
    logic [SXW-1:0]  r_s4_sx, n_s4_sx;
    logic [SYW-1:0]  r_s4_sy, n_s4_sy;
    logic [IDXW-1:0] r_s4_dst;

    // stage 5: output register
    logic [SXW-1:0]  w_sx_c;
    logic [SYW-1:0]  w_sy_c;
    logic [IDXW-1:0] r_s5_src, n_s5_src, r_s5_dst;

    //--------------------------------------------------------------------
    // Configuration port
    //--------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[AW-1:2]);
    assign w_wr      = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1x <= RST_C1X;
            r_c1y <= RST_C1Y;
            r_c2x <= RST_C2X;
            r_c2y <= RST_C2Y;
            r_c3x <= RST_C3X;
            r_c3y <= RST_C3Y;
            r_c4x <= RST_C4X;
            r_c4y <= RST_C4Y;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_C1X: r_c1x <= pwdata[XW-1:0];
                REG_C1Y: r_c1y <= pwdata[YW-1:0];
                REG_C2X: r_c2x <= pwdata[XW-1:0];
                REG_C2Y: r_c2y <= pwdata[YW-1:0];
                REG_C3X: r_c3x <= pwdata[XW-1:0];
                REG_C3Y: r_c3y <= pwdata[YW-1:0];
                REG_C4X: r_c4x <= pwdata[XW-1:0];
                REG_C4Y: r_c4y <= pwdata[YW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_C1X: prdata = 32'(r_c1x);
            REG_C1Y: prdata = 32'(r_c1y);
            REG_C2X: prdata = 32'(r_c2x);
            REG_C2Y: prdata = 32'(r_c2y);
            REG_C3X: prdata = 32'(r_c3x);
            REG_C3Y: prdata = 32'(r_c3y);
            REG_C4X: prdata = 32'(r_c4x);
            REG_C4Y: prdata = 32'(r_c4y);
            default: prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------
    // Pipeline control: a stage advances when empty or when its successor advances
    //--------------------------------------------------------------------
    assign w_s5_en = !r_s5_vld || i_out_ready;
    assign w_s4_en = !r_s4_vld || w_s5_en;
    assign w_s3_en = !r_s3_vld || w_s4_en;
    assign w_s2_en = !r_s2_vld || w_s3_en;
    assign w_s1_en = !r_s1_vld || w_s2_en;

    assign o_in_ready  = w_s1_en;
    assign o_out_valid = r_s5_vld;
    assign o_src_index = r_s5_src;
    assign o_dst_index = r_s5_dst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            if (w_s1_en) r_s1_vld <= i_in_valid;
            if (w_s2_en) r_s2_vld <= r_s1_vld;
            if (w_s3_en) r_s3_vld <= r_s2_vld;
            if (w_s4_en) r_s4_vld <= r_s3_vld;
            if (w_s5_en) r_s5_vld <= r_s4_vld;
        end
    end

    //--------------------------------------------------------------------
    // Stage 1: saturate the output coordinate
    //--------------------------------------------------------------------
    always_comb begin
        n_s1_x = (CW'(i_out_x) >= CW'(OUT_WIDTH))  ? XW'(OUT_WIDTH - 1)  : i_out_x;
        n_s1_y = (CW'(i_out_y) >= CW'(OUT_HEIGHT)) ? YW'(OUT_HEIGHT - 1) : i_out_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en) begin
            r_s1_x <= n_s1_x;
            r_s1_y <= n_s1_y;
        end
    end

    //--------------------------------------------------------------------
    // Stage 2: Q0.16 weights by reciprocal multiply, and the output index
    //--------------------------------------------------------------------
    always_comb begin
        w_prod_u = PRODW'(r_s1_x) * PRODW'(RECIP_U);
        w_prod_v = PRODW'(r_s1_y) * PRODW'(RECIP_V);
        n_s2_u   = QW'(w_prod_u >> (SHIFT_U - QW));
        n_s2_v   = QW'(w_prod_v >> (SHIFT_V - QW));
        n_s2_nu  = Q_ONE - QW1'(n_s2_u);
        n_s2_nv  = Q_ONE - QW1'(n_s2_v);
        n_s2_dst = IDXW'(r_s1_y) * IDXW'(OUT_WIDTH) + IDXW'(r_s1_x);
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en) begin
            r_s2_u   <= n_s2_u;
            r_s2_v   <= n_s2_v;
            r_s2_nu  <= n_s2_nu;
            r_s2_nv  <= n_s2_nv;
            r_s2_dst <= n_s2_dst;
        end
    end

    //--------------------------------------------------------------------
    // Stage 3: blend x along u, y along v
    //--------------------------------------------------------------------
    always_comb begin
        n_s3_top_x   = LXW'(r_c1x) * LXW'(r_s2_nu) + LXW'(r_c2x) * LXW'(r_s2_u);
        n_s3_bot_x   = LXW'(r_c4x) * LXW'(r_s2_nu) + LXW'(r_c3x) * LXW'(r_s2_u);
        n_s3_left_y  = LYW'(r_c1y) * LYW'(r_s2_nv) + LYW'(r_c4y) * LYW'(r_s2_v);
        n_s3_right_y = LYW'(r_c2y) * LYW'(r_s2_nv) + LYW'(r_c3y) * LYW'(r_s2_v);
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_en) begin
            r_s3_top_x   <= n_s3_top_x;
            r_s3_bot_x   <= n_s3_bot_x;
            r_s3_left_y  <= n_s3_left_y;
            r_s3_right_y <= n_s3_right_y;
            r_s3_u       <= r_s2_u;
            r_s3_v       <= r_s2_v;
            r_s3_nu      <= r_s2_nu;
            r_s3_nv      <= r_s2_nv;
            r_s3_dst     <= r_s2_dst;
        end
    end

    //--------------------------------------------------------------------
    // Stage 4: blend x along v, y along u; keep the integer part of Q.32
    //--------------------------------------------------------------------
    always_comb begin
        w_sx_full = BXW'(r_s3_top_x) * BXW'(r_s3_nv) + BXW'(r_s3_bot_x) * BXW'(r_s3_v);
        w_sy_full = BYW'(r_s3_left_y) * BYW'(r_s3_nu) + BYW'(r_s3_right_y) * BYW'(r_s3_u);
        n_s4_sx   = w_sx_full[BXW-1:2*QW];
        n_s4_sy   = w_sy_full[BYW-1:2*QW];
    end

    always_ff @(posedge i_clk) begin
        if (w_s4_en) begin
            r_s4_sx  <= n_s4_sx;
            r_s4_sy  <= n_s4_sy;
            r_s4_dst <= r_s3_dst;
        end
    end

    //--------------------------------------------------------------------
    // Stage 5: saturate to the source image and form the linear index
    //--------------------------------------------------------------------
    always_comb begin
        w_sx_c   = (CW'(r_s4_sx) >= CW'(IN_WIDTH))  ? SXW'(IN_WIDTH - 1)  : r_s4_sx;
        w_sy_c   = (CW'(r_s4_sy) >= CW'(IN_HEIGHT)) ? SYW'(IN_HEIGHT - 1) : r_s4_sy;
        n_s5_src = IDXW'(w_sy_c) * IDXW'(IN_WIDTH) + IDXW'(w_sx_c);
    end

    always_ff @(posedge i_clk) begin
        if (w_s5_en) begin
            r_s5_src <= n_s5_src;
            r_s5_dst <= r_s4_dst;
        end
    end

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    `QWAG_ASSERT_NOW(a_weights_sum_one, r_s2_vld, (QW1'(r_s2_u) + r_s2_nu) == Q_ONE, "weights do not sum to one")
    `QWAG_ASSERT_NEXT(a_s4_held_on_stall, r_s4_vld && !w_s5_en, r_s4_vld, "beat dropped in stage 4 during stall")
    `QWAG_ASSERT_NOW(a_ready_when_drained, !r_s5_vld, o_in_ready, "input stalled while output register is empty")
    `QWAG_ASSERT_NOW(a_src_in_range, o_out_valid, 64'(o_src_index) < SRC_LIMIT, "source index outside image")
    `QWAG_ASSERT_NOW(a_dst_in_range, o_out_valid, 64'(o_dst_index) < DST_LIMIT, "output index outside image")

endmodule
